// ===== rtl/core/pqwd_pkg.sv =====
// Shared constants, codes and types for the priority job dispatcher.
package pqwd_pkg;

    // Queue size and worker count.
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_WORKERS = 4;

    // Derived widths.
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths of the item and result ports.
    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int IDLE_W = 4;
    localparam int WIDX_W = 2;
    localparam int QCNT_W = 5;

    // Command codes.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Running best entry handed from cell to cell during a scan.
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
        logic [IDX_W-1:0]  idx;
    } scan_tok_t;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic              wr_en;
        logic [ID_W-1:0]   wr_id;
        logic [PRIO_W-1:0] wr_prio;
        logic              remove;
        logic [IDX_W-1:0]  remove_idx;
        logic [CNT_W-1:0]  count;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/pqwd_cell.sv =====
// One queue slot: holds a job, compares it against the passing best, shifts on removal.
module pqwd_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pqwd_pkg::IDX_W-1:0]    my_index,
    input  pqwd_pkg::cell_ctrl_t          ctrl,
    input  logic [pqwd_pkg::ID_W-1:0]     nbr_id,
    input  logic [pqwd_pkg::PRIO_W-1:0]   nbr_prio,
    input  pqwd_pkg::scan_tok_t           tok_in,
    output logic [pqwd_pkg::ID_W-1:0]     id,
    output logic [pqwd_pkg::PRIO_W-1:0]   prio,
    output pqwd_pkg::scan_tok_t           tok_out
);

    logic [pqwd_pkg::ID_W-1:0]   id_reg;
    logic [pqwd_pkg::ID_W-1:0]   id_next;
    logic [pqwd_pkg::PRIO_W-1:0] prio_reg;
    logic [pqwd_pkg::PRIO_W-1:0] prio_next;
    pqwd_pkg::scan_tok_t         tok_reg;
    pqwd_pkg::scan_tok_t         tok_next;
    logic                        occupied;

    // The slot holds a live job when its index is below the fill count.
    assign occupied = (pqwd_pkg::CNT_W'(my_index) < ctrl.count);

    // Load on add at the tail, take the upper neighbor's job on removal.
    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.wr_en && (pqwd_pkg::CNT_W'(my_index) == ctrl.count))
        begin
            id_next   = ctrl.wr_id;
            prio_next = ctrl.wr_prio;
        end
        else if (ctrl.remove && (my_index >= ctrl.remove_idx))
        begin
            id_next   = nbr_id;
            prio_next = nbr_prio;
        end
    end

    // Replace the running best only on strictly higher priority, so the
    // earliest queued job wins a tie.
    always_comb
    begin
        tok_next = tok_in;
        if (occupied && (!tok_in.found || (prio_reg > tok_in.prio)))
        begin
            tok_next.found = 1'b1;
            tok_next.prio  = prio_reg;
            tok_next.id    = id_reg;
            tok_next.idx   = my_index;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    // Scan stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign id      = id_reg;
    assign prio    = prio_reg;
    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/priority_queue_worker_dispatch.sv =====
// Top level of the priority job dispatcher: controller, row of queue cells, result register.
//
//   Channel  Signals                                    Direction  Moves
//   item     item_valid / item_stall + payload fields   in         add or tick command
//   result   result_valid / result_stall + fields       out        one result per item
//   config   cfg_we / cfg_data                          in         paused register
//
// An add, and a tick that dispatches nothing, leave their result in the output
// register at the edge that accepts the item. A dispatching tick registers its
// result once the scan is done: the best job travels one cell per cycle down the
// row of QUEUE_DEPTH cells, then the job is removed and the result registered.
// The controller returns to idle as that result is registered; only then can the next item be accepted.
// Reset empties the queue and clears paused; queue contents are not cleared.
// A stalled result holds in the output register and new items are stalled.
module priority_queue_worker_dispatch
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                cmd,
    input  logic [pqwd_pkg::ID_W-1:0]           job_id,
    input  logic [pqwd_pkg::PRIO_W-1:0]         job_priority,
    input  logic [pqwd_pkg::IDLE_W-1:0]         idle_workers,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                dispatched,
    output logic [pqwd_pkg::WIDX_W-1:0]         worker_index,
    output logic [pqwd_pkg::ID_W-1:0]           out_job_id,
    output logic [pqwd_pkg::PRIO_W-1:0]         out_priority,
    output logic [pqwd_pkg::QCNT_W-1:0]         queue_count,
    output logic                                dropped
);

    pqwd_pkg::state_t                  state_reg;
    pqwd_pkg::state_t                  state_next;
    logic [pqwd_pkg::CNT_W-1:0]        scan_cnt_reg;
    logic [pqwd_pkg::CNT_W-1:0]        scan_cnt_next;
    logic [pqwd_pkg::CNT_W-1:0]        count_reg;
    logic [pqwd_pkg::CNT_W-1:0]        count_next;
    logic                              paused_reg;
    logic [pqwd_pkg::WIDX_W-1:0]       worker_reg;
    logic [pqwd_pkg::WIDX_W-1:0]       worker_next;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              dispatched_reg;
    logic                              dispatched_next;
    logic [pqwd_pkg::WIDX_W-1:0]       worker_index_reg;
    logic [pqwd_pkg::WIDX_W-1:0]       worker_index_next;
    logic [pqwd_pkg::ID_W-1:0]         out_job_id_reg;
    logic [pqwd_pkg::ID_W-1:0]         out_job_id_next;
    logic [pqwd_pkg::PRIO_W-1:0]       out_priority_reg;
    logic [pqwd_pkg::PRIO_W-1:0]       out_priority_next;
    logic [pqwd_pkg::QCNT_W-1:0]       queue_count_reg;
    logic [pqwd_pkg::QCNT_W-1:0]       queue_count_next;
    logic                              dropped_reg;
    logic                              dropped_next;

    logic                              item_acc;
    logic                              out_take;
    logic                              scan_done;
    logic                              worker_found;
    logic [pqwd_pkg::WIDX_W-1:0]       worker_pick;
    pqwd_pkg::cell_ctrl_t              ctrl;

    pqwd_pkg::scan_tok_t               tok [pqwd_pkg::QUEUE_DEPTH+1];
    logic [pqwd_pkg::ID_W-1:0]         cell_id [pqwd_pkg::QUEUE_DEPTH];
    logic [pqwd_pkg::PRIO_W-1:0]       cell_prio [pqwd_pkg::QUEUE_DEPTH];

    // Handshakes.
    assign item_stall = (state_reg != pqwd_pkg::ST_IDLE) || (out_valid_reg && result_stall);
    assign item_acc   = item_valid && !item_stall;
    assign out_take   = out_valid_reg && !result_stall;
    assign scan_done  = (state_reg == pqwd_pkg::ST_SCAN)
                        && (scan_cnt_reg == pqwd_pkg::CNT_W'(pqwd_pkg::QUEUE_DEPTH));

    // Lowest-numbered idle worker.
    always_comb
    begin
        worker_found = 1'b0;
        worker_pick  = '0;
        for (int w = pqwd_pkg::NUM_WORKERS - 1; w >= 0; w--)
        begin
            if (idle_workers[w])
            begin
                worker_found = 1'b1;
                worker_pick  = pqwd_pkg::WIDX_W'(w);
            end
        end
    end

    // Controller: next state, queue count and result register.
    always_comb
    begin
        state_next        = state_reg;
        scan_cnt_next     = scan_cnt_reg;
        count_next        = count_reg;
        worker_next       = worker_reg;
        out_valid_next    = out_valid_reg && !out_take;
        dispatched_next   = dispatched_reg;
        worker_index_next = worker_index_reg;
        out_job_id_next   = out_job_id_reg;
        out_priority_next = out_priority_reg;
        queue_count_next  = queue_count_reg;
        dropped_next      = dropped_reg;

        ctrl.wr_en      = 1'b0;
        ctrl.wr_id      = job_id;
        ctrl.wr_prio    = job_priority;
        ctrl.remove     = 1'b0;
        ctrl.remove_idx = tok[pqwd_pkg::QUEUE_DEPTH].idx;
        ctrl.count      = count_reg;

        case (state_reg)
            pqwd_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    out_valid_next    = 1'b1;
                    dispatched_next   = 1'b0;
                    worker_index_next = '0;
                    out_job_id_next   = '0;
                    out_priority_next = '0;
                    dropped_next      = 1'b0;
                    queue_count_next  = pqwd_pkg::QCNT_W'(count_reg);
                    if (cmd == pqwd_pkg::CMD_ADD)
                    begin
                        if (count_reg >= pqwd_pkg::CNT_W'(pqwd_pkg::QUEUE_DEPTH))
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.wr_en       = 1'b1;
                            count_next       = count_reg + 1'b1;
                            queue_count_next = pqwd_pkg::QCNT_W'(count_reg + 1'b1);
                        end
                    end
                    else if (!paused_reg && (count_reg != '0) && worker_found)
                    begin
                        // Result waits for the scan to finish.
                        out_valid_next = 1'b0;
                        worker_next    = worker_pick;
                        scan_cnt_next  = '0;
                        state_next     = pqwd_pkg::ST_SCAN;
                    end
                end
            end
            pqwd_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_done)
                begin
                    ctrl.remove       = 1'b1;
                    count_next        = count_reg - 1'b1;
                    out_valid_next    = 1'b1;
                    dispatched_next   = 1'b1;
                    worker_index_next = worker_reg;
                    out_job_id_next   = tok[pqwd_pkg::QUEUE_DEPTH].id;
                    out_priority_next = tok[pqwd_pkg::QUEUE_DEPTH].prio;
                    queue_count_next  = pqwd_pkg::QCNT_W'(count_reg - 1'b1);
                    dropped_next      = 1'b0;
                    state_next        = pqwd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pqwd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pqwd_pkg::ST_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            paused_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                paused_reg <= cfg_data;
            end
        end
    end

    // Result payload and chosen worker.
    always_ff @(posedge clk)
    begin
        worker_reg       <= worker_next;
        dispatched_reg   <= dispatched_next;
        worker_index_reg <= worker_index_next;
        out_job_id_reg   <= out_job_id_next;
        out_priority_reg <= out_priority_next;
        queue_count_reg  <= queue_count_next;
        dropped_reg      <= dropped_next;
    end

    // Row of queue cells; the scan enters at cell zero with no best yet.
    assign tok[0] = '0;

    for (genvar i = 0; i < pqwd_pkg::QUEUE_DEPTH; i++)
    begin : g_cell
        logic [pqwd_pkg::ID_W-1:0]   nbr_id;
        logic [pqwd_pkg::PRIO_W-1:0] nbr_prio;

        if (i == pqwd_pkg::QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr_id   = '0;
            assign nbr_prio = '0;
        end
        else
        begin : g_mid
            assign nbr_id   = cell_id[i+1];
            assign nbr_prio = cell_prio[i+1];
        end

        pqwd_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_index (pqwd_pkg::IDX_W'(i)),
            .ctrl     (ctrl),
            .nbr_id   (nbr_id),
            .nbr_prio (nbr_prio),
            .tok_in   (tok[i]),
            .id       (cell_id[i]),
            .prio     (cell_prio[i]),
            .tok_out  (tok[i+1])
        );
    end

    // Outputs.
    assign result_valid = out_valid_reg;
    assign dispatched   = dispatched_reg;
    assign worker_index = worker_index_reg;
    assign out_job_id   = out_job_id_reg;
    assign out_priority = out_priority_reg;
    assign queue_count  = queue_count_reg;
    assign dropped      = dropped_reg;

    // A finished scan over a non-empty queue always carries a job.
    a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> tok[pqwd_pkg::QUEUE_DEPTH].found)
        else $error("scan finished without a job");

    // The result register is free when a dispatch completes.
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> !out_valid_reg)
        else $error("dispatch result would overwrite a pending result");

    // A dispatch lowers the queue count by one.
    a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count not decremented on dispatch");

    // The fill count never passes the queue depth.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pqwd_pkg::CNT_W'(pqwd_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule
